@@ rtl/csem_pkg.sv @@
package csem_pkg;

  localparam int unsigned IdW    = 5;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned CountW = 16;

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_SIG    = 2'd1,
    OP_SIG_IRQ = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ACQUIRED  = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_BLOCKED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_COUNTED   = 3'd4,
    ST_WOKE      = 3'd5,
    ST_SATURATED = 3'd6
  } status_e;

  localparam logic CfgInitial = 1'b0;
  localparam logic CfgMax     = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] task_priority;
    logic             may_block;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              woken_valid;
    logic [IdW-1:0]    woken_task;
    logic              switch_request;
    logic [CountW-1:0] count_now;
    logic [4:0]        waiters_now;
  } rsp_t;

endpackage

@@ rtl/counting_semaphore_priority_wait.sv @@
// channel | direction | handshake           | payload
// req     | in        | req_valid_i/stall_o | req_i  (opcode, task, priority, may_block)
// rsp     | out       | rsp_valid_o/stall_i | rsp_o  (status, woken task, switch, counts)
// cfg     | in        | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//
// one item at a time; a wait or signal without queue walk finishes in S_DEC
// a blocking insert walks the list from the tail, one memory read and one write
// per cycle; a signal that wakes a waiter shifts the list forward the same way
// a result waits in the output register; next item is taken once it is sent
// reset clears counts and list length; the waiter memory needs no clearing
module counting_semaphore_priority_wait
  import csem_pkg::*;
#(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned NW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned EW = IdW + PrioW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2; // read returned for entry k-1
  localparam logic [2:0] S_HEAD  = 3'd3; // head read returned
  localparam logic [2:0] S_SHF   = 3'd4; // read returned for entry k
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  req_t              req_q;
  logic [15:0]       max_q, cnt_q;
  logic [NW-1:0]     tot_q;
  logic [NW-1:0]     k_q, k_d;
  logic [IdW-1:0]    head_q;
  logic              hp_lt_q;
  rsp_t              rsp_q;
  logic              rv_q;

  // waiter memory
  logic [EW-1:0]     mem [MAX_WAITERS];
  logic [EW-1:0]     rd_q;
  logic              re, we;
  logic [AW-1:0]     ra, wa;
  logic [EW-1:0]     wd;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  assign req_stall_o = (state_q != S_IDLE) || rv_q;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  logic [PrioW-1:0] rd_prio;
  logic [IdW-1:0]   rd_id;
  assign rd_prio = rd_q[PrioW-1:0];
  assign rd_id   = rd_q[EW-1:PrioW];

  // zero maximum taken as one
  logic [15:0] cfg_max;
  assign cfg_max = (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;

  logic        fin;
  rsp_t        res;
  logic [15:0] cnt_d;
  logic [NW-1:0] tot_d;

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    re = 1'b0; ra = '0; we = 1'b0; wa = '0; wd = {req_q.task_id, req_q.task_priority};
    fin = 1'b0;
    res = '0;
    cnt_d = cnt_q;
    tot_d = tot_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i && !req_stall_o && req_i.opcode != OP_NONE) state_d = S_DEC;
      S_DEC: begin
        if (req_q.opcode == OP_WAIT) begin
          if (cnt_q != 16'd0) begin
            cnt_d = cnt_q - 16'd1; fin = 1'b1; res.status = ST_ACQUIRED;
          end else if (!req_q.may_block) begin
            fin = 1'b1; res.status = ST_TIMEOUT;
          end else if (tot_q >= NW'(MAX_WAITERS)) begin
            fin = 1'b1; res.status = ST_FULL;
          end else if (tot_q == '0) begin
            we = 1'b1; wa = '0; tot_d = tot_q + 1'b1;
            fin = 1'b1; res.status = ST_BLOCKED; res.switch_request = 1'b1;
          end else begin
            re = 1'b1; ra = AW'(tot_q - 1'b1); k_d = tot_q; state_d = S_INS;
          end
        end else if (tot_q != '0) begin
          re = 1'b1; ra = '0; state_d = S_HEAD;
        end else begin
          if (cnt_q < max_q) begin
            cnt_d = cnt_q + 16'd1; res.status = ST_COUNTED;
          end else res.status = ST_SATURATED;
          res.switch_request = (req_q.opcode == OP_SIG_IRQ);
          fin = 1'b1;
        end
      end
      S_INS: begin
        // rd_q holds entry k-1
        if (rd_prio > req_q.task_priority) begin
          we = 1'b1; wa = AW'(k_q); wd = rd_q;
          if (k_q == NW'(1)) begin
            state_d = S_OUT; k_d = '0;
          end else begin
            re = 1'b1; ra = AW'(k_q - NW'(2)); k_d = k_q - 1'b1;
          end
        end else state_d = S_OUT;
      end
      S_HEAD: begin
        res.switch_request = 1'b0;
        if (tot_q == NW'(1)) begin
          state_d = S_OUT; k_d = '0;
        end else begin
          re = 1'b1; ra = AW'(NW'(1)); k_d = NW'(1); state_d = S_SHF;
        end
      end
      S_SHF: begin
        we = 1'b1; wa = AW'(k_q - 1'b1); wd = rd_q;
        if (k_q + 1'b1 >= tot_q) state_d = S_OUT;
        else begin
          re = 1'b1; ra = AW'(k_q + 1'b1); k_d = k_q + 1'b1;
        end
      end
      S_OUT: begin
        fin = 1'b1;
        if (req_q.opcode == OP_WAIT) begin
          we = 1'b1; wa = AW'(k_q); tot_d = tot_q + 1'b1;
          res.status = ST_BLOCKED; res.switch_request = 1'b1;
        end else begin
          tot_d = tot_q - 1'b1;
          res.status = ST_WOKE; res.woken_valid = 1'b1; res.woken_task = head_q;
          res.switch_request = (req_q.opcode == OP_SIG_IRQ) || hp_lt_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res.count_now = cnt_d;
    res.waiters_now = 5'(tot_d);
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q <= 1'b0;
      max_q <= 16'd1;
      cnt_q <= '0;
      tot_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      if (fin) rv_q <= 1'b1;
      else if (rv_q && !rsp_stall_i) rv_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgInitial) begin
          cnt_q <= (cfg_data_i <= max_q) ? cfg_data_i : max_q;
          tot_q <= '0;
        end else begin
          max_q <= cfg_max;
          cnt_q <= (cnt_q > cfg_max) ? cfg_max : cnt_q;
          tot_q <= tot_d;
        end
      end else begin
        cnt_q <= cnt_d;
        tot_q <= tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && !req_stall_o) req_q <= req_i;
    if (fin) rsp_q <= res;
    if (state_q == S_HEAD) begin
      head_q <= rd_id;
      hp_lt_q <= rd_prio < req_q.task_priority;
    end
  end

  // list length never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) tot_q <= NW'(MAX_WAITERS))
    else $error("waiter count overflow");
  // token count stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= max_q)
    else $error("token count above max");
  // a result is produced only from a working state
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin |-> state_q != S_IDLE)
    else $error("result from idle");
  // memory is not written while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == S_IDLE |-> !we)
    else $error("write while idle");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
  import csem_pkg::*;
();

  localparam int unsigned NumWaiters = 16;
  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } waiter_t;

  // semaphore predictor plus queue of expected responses
  class sem_scoreboard;
    logic [15:0] init_cnt;
    logic [15:0] max_cnt;
    logic [15:0] tokens;
    waiter_t     waiters[$];
    rsp_t        pending[$];
    int          mismatches;

    function new();
      init_cnt   = '0;
      max_cnt    = 16'd1;
      tokens     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == CfgInitial) begin
        init_cnt = data;
        tokens   = (init_cnt <= max_cnt) ? init_cnt : max_cnt;
        waiters.delete();
      end else begin
        max_cnt = (data == 16'd0) ? 16'd1 : data;
        if (tokens > max_cnt) tokens = max_cnt;
      end
    endfunction

    function void note_request(req_t r);
      rsp_t    e;
      waiter_t w;
      int      pos;
      if (r.opcode == OP_NONE) return;
      e = '0;
      if (r.opcode == OP_WAIT) begin
        if (tokens != 0) begin
          tokens   = tokens - 1;
          e.status = ST_ACQUIRED;
        end else if (!r.may_block) begin
          e.status = ST_TIMEOUT;
        end else if (waiters.size() >= NumWaiters) begin
          e.status = ST_FULL;
        end else begin
          // equal priorities stay in arrival order
          pos = 0;
          while (pos < waiters.size() && waiters[pos].prio <= r.task_priority) pos++;
          w.id   = r.task_id;
          w.prio = r.task_priority;
          waiters.insert(pos, w);
          e.status         = ST_BLOCKED;
          e.switch_request = 1'b1;
        end
      end else begin
        if (waiters.size() != 0) begin
          w = waiters.pop_front();
          e.status      = ST_WOKE;
          e.woken_valid = 1'b1;
          e.woken_task  = w.id;
          if (r.opcode == OP_SIG && w.prio < r.task_priority) e.switch_request = 1'b1;
        end else if (tokens < max_cnt) begin
          tokens   = tokens + 1;
          e.status = ST_COUNTED;
        end else begin
          e.status = ST_SATURATED;
        end
        if (r.opcode == OP_SIG_IRQ) e.switch_request = 1'b1;
      end
      e.count_now   = tokens;
      e.waiters_now = 5'(waiters.size());
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.woken_valid !== e.woken_valid ||
          got.woken_task !== e.woken_task || got.switch_request !== e.switch_request ||
          got.count_now !== e.count_now || got.waiters_now !== e.waiters_now) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"response mismatch: exp st=%0d wv=%0d wt=%0d sw=%0d cnt=%0d n=%0d,",
                    " got st=%0d wv=%0d wt=%0d sw=%0d cnt=%0d n=%0d"},
                   e.status, e.woken_valid, e.woken_task, e.switch_request, e.count_now,
                   e.waiters_now, got.status, got.woken_valid, got.woken_task,
                   got.switch_request, got.count_now, got.waiters_now);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_stall_o;
  req_t        req_i = '0;
  logic        rsp_valid_o;
  logic        rsp_stall_i = 1'b0;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  sem_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  calm;       // no idling on either side in the last stretch
  bit  sink_idle;  // response side allowed to stall

  always #5 clk_i = ~clk_i;

  counting_semaphore_priority_wait dut (.*);

  // any accepted item resets the watchdog
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // response sink with random stall bursts
  always @(posedge clk_i) begin
    if (rsp_valid_o && !rsp_stall_i) sb.check_response(rsp_o);
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && sink_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        rsp_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      rsp_stall_i <= 1'b0;
    end
  end

  // valid stays high across back to back items and drops only when idling
  task automatic send_req(req_t r);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 13);
      req_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic op(op_e o, int id, int prio, bit blk);
    req_t r;
    r.opcode        = o;
    r.task_id       = IdW'(id);
    r.task_priority = PrioW'(prio);
    r.may_block     = blk;
    send_req(r);
  endtask

  // registers only change with nothing in flight
  task automatic write_reg(logic idx, logic [15:0] data);
    req_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_op(int blk_pct, int wait_pct);
    req_t r;
    r = req_t'(16'($urandom));
    if ($urandom_range(0, 99) < 3) r.opcode = OP_NONE;
    else if ($urandom_range(0, 99) < wait_pct) r.opcode = OP_WAIT;
    else r.opcode = $urandom_range(0, 1) ? OP_SIG : OP_SIG_IRQ;
    r.may_block = ($urandom_range(0, 99) < blk_pct);
    // narrow priorities now and then so ties are common
    if ($urandom_range(0, 2) == 0) r.task_priority = PrioW'($urandom_range(0, 3));
    send_req(r);
  endtask

  initial begin
    calm        = 1'b0;
    sink_idle   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state has no tokens, max one
    op(OP_WAIT, 0, 0, 1'b0);           // timeout
    op(OP_SIG, 1, 10, 1'b0);           // counted
    op(OP_SIG, 1, 10, 1'b0);           // saturated
    op(OP_WAIT, 31, 255, 1'b0);        // acquired
    op(OP_NONE, 5, 5, 1'b1);           // unused opcode, no response
    // fill the list with ties and extremes, repeated waiter included
    for (int i = 0; i < 16; i++) op(OP_WAIT, i % 12, (i % 3) * 127, 1'b1);
    op(OP_WAIT, 31, 0, 1'b1);          // full list
    op(OP_SIG, 3, 0, 1'b0);            // woken waiter not more urgent
    op(OP_SIG, 3, 255, 1'b0);          // woken waiter outranks
    op(OP_SIG_IRQ, 0, 0, 1'b0);

    write_reg(CfgMax, 16'd0);          // zero maximum taken as one
    write_reg(CfgInitial, 16'hFFFF);   // clipped, list emptied
    op(OP_WAIT, 2, 2, 1'b1);
    write_reg(CfgMax, 16'hFFFF);
    write_reg(CfgInitial, 16'hFFFF);
    op(OP_SIG_IRQ, 7, 7, 1'b0);        // saturated at top
    op(OP_WAIT, 7, 7, 1'b0);
    write_reg(CfgMax, 16'd3);          // lowered maximum clips tokens
    op(OP_SIG, 1, 1, 1'b0);

    // random phases over several settings
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: write_reg(CfgMax, 16'($urandom_range(1, 4)));
        1: write_reg(CfgMax, 16'($urandom));
        default: write_reg(CfgMax, 16'hFFFF);
      endcase
      write_reg(CfgInitial, (ph == 4) ? 16'hFFFF : 16'($urandom_range(0, 3)));
      sink_idle = (ph != 2);
      for (int i = 0; i < 120; i++) random_op(85, (ph % 2) ? 65 : 45);
    end
    write_reg(CfgInitial, 16'd0);
    calm = 1'b1;
    for (int i = 0; i < 200; i++) random_op(85, 55);
    req_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
